FILE: hw/rtl/bmf_pkg.sv
// Shared types and constants for the box mean filter with border.
package bmf_pkg;

   localparam int PIX_W    = 8;
   localparam int DIM_W    = 11;
   localparam int KER_W    = 3;
   localparam int HALF_W   = 3;
   localparam int DIVR_W   = 6;
   localparam int OUT_POS_W = 10;
   localparam int APB_DATA_W = 32;
   localparam int APB_ADDR_W = 4;

   localparam logic [PIX_W-1:0] BORDER_VALUE = 8'd255;

   localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] REG_KERNEL_SIZE   = 2'd2;
   localparam logic [1:0] REG_BORDER_MARGIN = 2'd3;

   localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 11'd640;
   localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 11'd480;
   localparam logic [KER_W-1:0] RST_KERNEL_SIZE   = 3'd3;
   localparam logic [DIM_W-1:0] RST_BORDER_MARGIN = 11'd0;

   typedef struct packed {
      logic [DIM_W-1:0] image_width;
      logic [DIM_W-1:0] image_height;
      logic [KER_W-1:0] kernel_size;
      logic [DIM_W-1:0] border_margin;
   } cfg_type;

endpackage

FILE: hw/rtl/bmf_csr.sv
// Configuration registers behind the APB-style port.
module bmf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bmf_pkg::APB_ADDR_W-1:0]  paddr,
   input  logic [bmf_pkg::APB_DATA_W-1:0]  pwdata,
   output logic [bmf_pkg::APB_DATA_W-1:0]  prdata,
   output logic                            pready,
   output bmf_pkg::cfg_type                cfg
);
   import bmf_pkg::*;

   cfg_type    cfg_ff;
   logic [1:0] reg_idx;
   logic       wr_fire;

   assign reg_idx = paddr[3:2];
   assign wr_fire = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width   <= RST_IMAGE_WIDTH;
         cfg_ff.image_height  <= RST_IMAGE_HEIGHT;
         cfg_ff.kernel_size   <= RST_KERNEL_SIZE;
         cfg_ff.border_margin <= RST_BORDER_MARGIN;
      end else if (wr_fire) begin
         case (reg_idx)
            REG_IMAGE_WIDTH:   cfg_ff.image_width   <= pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT:  cfg_ff.image_height  <= pwdata[DIM_W-1:0];
            REG_KERNEL_SIZE:   cfg_ff.kernel_size   <= pwdata[KER_W-1:0];
            REG_BORDER_MARGIN: cfg_ff.border_margin <= pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:   prdata = APB_DATA_W'(cfg_ff.image_width);
         REG_IMAGE_HEIGHT:  prdata = APB_DATA_W'(cfg_ff.image_height);
         REG_KERNEL_SIZE:   prdata = APB_DATA_W'(cfg_ff.kernel_size);
         REG_BORDER_MARGIN: prdata = APB_DATA_W'(cfg_ff.border_margin);
         default:           prdata = '0;
      endcase
   end

endmodule

FILE: hw/rtl/bmf_line_mem.sv
// Line store memory: one word per column holding that column of the past rows.
module bmf_line_mem #(
   parameter int DEPTH  = 1024,
   parameter int DATA_W = 48
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [DATA_W-1:0]         rd_data,
   input  logic                      wr_en,
   input  logic [$clog2(DEPTH)-1:0]  wr_addr,
   input  logic [DATA_W-1:0]         wr_data
);
   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

FILE: hw/rtl/bmf_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module bmf_divider #(
   parameter int NUM_W = 14,
   parameter int DEN_W = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_shift;
   logic             fits;

   assign rem_shift = {rem_ff, quo_ff[NUM_W-1]};
   assign fits      = rem_shift >= {1'b0, den_ff};
   assign done      = done_ff;
   assign quot      = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= numer;
         rem_ff <= '0;
         den_ff <= denom;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= DEN_W'(rem_shift - {1'b0, den_ff});
         end else begin
            rem_ff <= rem_shift[DEN_W-1:0];
         end
         quo_ff <= {quo_ff[NUM_W-2:0], fits};
      end
   end

endmodule

FILE: hw/rtl/box_mean_filter_with_border.sv
// Box mean filter with border: a filtered result passes through the window shift, the column sums,
// the bit-serial divider, the result load and the output load after its transaction is accepted;
// a border result passes through the window shift and the output load. One input transaction is
// worked at a time, and a result waiting on a stalled output holds the next transaction back.
// Synchronous active-high reset clears the position counters, window, handshake state and
// registers; the line store is not cleared.
module box_mean_filter_with_border #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   parameter int MAX_KERNEL = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [bmf_pkg::PIX_W-1:0]           req_luma,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [bmf_pkg::OUT_POS_W-1:0]       rsp_out_row,
   output logic [bmf_pkg::OUT_POS_W-1:0]       rsp_out_col,
   output logic [bmf_pkg::PIX_W-1:0]           rsp_filtered_luma,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [bmf_pkg::APB_ADDR_W-1:0]      paddr,
   input  logic [bmf_pkg::APB_DATA_W-1:0]      pwdata,
   output logic [bmf_pkg::APB_DATA_W-1:0]      prdata,
   output logic                                pready
);
   import bmf_pkg::*;

   // Window geometry. The line store keeps WIN-1 past rows, packed per column.
   localparam int WIN    = MAX_KERNEL;
   localparam int LINES  = (MAX_KERNEL > 1) ? MAX_KERNEL - 1 : 1;
   localparam int MEM_W  = LINES * PIX_W;
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int CWW    = (WW > DIM_W) ? WW : DIM_W;
   localparam int CWH    = (HW > DIM_W) ? HW : DIM_W;
   localparam int SW0    = (WW > HW) ? WW : HW;
   localparam int SW     = ((SW0 > DIM_W) ? SW0 : DIM_W) + 2;
   localparam int IDX_W  = $clog2(WIN + 1);
   localparam int SUM_W  = $clog2(WIN * WIN * 255 + 1);
   localparam int HMAX   = (MAX_KERNEL - 1) / 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   cfg_type cfg;

   bmf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Effective frame size: the configured size held to one up to the maximum.
   logic [CWW-1:0] iw_ext;
   logic [CWH-1:0] ih_ext;
   logic [WW-1:0]  w_eff;
   logic [HW-1:0]  h_eff;

   assign iw_ext = CWW'(cfg.image_width);
   assign ih_ext = CWH'(cfg.image_height);

   always_comb begin
      if (iw_ext == '0) begin
         w_eff = WW'(1);
      end else if (iw_ext > CWW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(iw_ext);
      end
      if (ih_ext == '0) begin
         h_eff = HW'(1);
      end else if (ih_ext > CWH'(MAX_HEIGHT)) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(ih_ext);
      end
   end

   // Half kernel, clamped to what the window holds, and the divisor k*k.
   logic [HALF_W-1:0] half_raw;
   logic [HALF_W-1:0] half;
   logic [DIVR_W-1:0] divisor;
   logic [DIVR_W-1:0] k_sq;
   logic [IDX_W-1:0]  lo;

   assign half_raw = (cfg.kernel_size >= KER_W'(1)) ?
                     HALF_W'((cfg.kernel_size - KER_W'(1)) >> 1) : '0;
   assign half     = (half_raw > HALF_W'(HMAX)) ? HALF_W'(HMAX) : half_raw;
   assign k_sq     = DIVR_W'(cfg.kernel_size) * DIVR_W'(cfg.kernel_size);
   assign divisor  = (k_sq == '0) ? DIVR_W'(1) : k_sq;
   // First window row and column that belong to the active kernel.
   assign lo       = IDX_W'(WIN - 1) - IDX_W'({half, 1'b0});

   // Position counters. A counter left beyond a newly written size restarts at zero.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] c_now;
   logic [ROW_W-1:0] r_now;
   logic [WW-1:0]    col_inc;
   logic [HW-1:0]    row_inc;
   logic             accept;

   assign accept = req_valid && req_ready;
   assign c_now  = (WW'(col_ff) >= w_eff) ? '0 : col_ff;
   assign r_now  = (HW'(row_ff) >= h_eff) ? '0 : row_ff;
   assign col_inc = WW'(c_now) + WW'(1);
   assign row_inc = HW'(r_now) + HW'(1);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_inc >= w_eff) begin
            col_in = '0;
            row_in = (row_inc >= h_eff) ? '0 : ROW_W'(row_inc);
         end else begin
            col_in = COL_W'(col_inc);
            row_in = r_now;
         end
      end
   end

   // Line store: read the column at acceptance, write back the shifted column in the next state.
   logic [MEM_W-1:0] rd_data;
   logic [MEM_W-1:0] wr_data;
   logic             wr_en;
   state_type        state_ff;
   logic [COL_W-1:0] c_ff;
   logic [ROW_W-1:0] r_ff;
   logic [PIX_W-1:0] luma_ff;

   assign wr_en = (state_ff == ST_SHIFT);

   bmf_line_mem #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (MEM_W)
   ) u_line_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (c_now),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (c_ff),
      .wr_data (wr_data)
   );

   // Line 0 takes the new pixel and every other line takes the one above it.
   // The new window column runs from the oldest row down to the new pixel.
   logic [PIX_W-1:0] column [WIN];

   always_comb begin
      wr_data = rd_data;
      wr_data[PIX_W-1:0] = luma_ff;
      for (int j = 1; j < LINES; j++) begin
         wr_data[j*PIX_W +: PIX_W] = rd_data[(j-1)*PIX_W +: PIX_W];
      end
      for (int i = 0; i < WIN - 1; i++) begin
         column[i] = rd_data[(WIN-2-i)*PIX_W +: PIX_W];
      end
      column[WIN-1] = luma_ff;
   end

   // Window registers, shifted one column left as each pixel arrives.
   logic [PIX_W-1:0] win_ff [WIN][WIN];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (state_ff == ST_SHIFT) begin
         for (int i = 0; i < WIN; i++) begin
            for (int j = 0; j < WIN - 1; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
            win_ff[i][WIN-1] <= column[i];
         end
      end
   end

   // Centre position and border test, compared as signed values; the emit test compares unsigned.
   logic signed [SW-1:0] cr, cc, bm, hgt_s, wid_s;
   logic                 emit;
   logic                 in_border;

   assign cr    = $signed(SW'(r_ff)) - $signed(SW'(half));
   assign cc    = $signed(SW'(c_ff)) - $signed(SW'(half));
   assign bm    = $signed(SW'(cfg.border_margin));
   assign hgt_s = $signed(SW'(h_eff));
   assign wid_s = $signed(SW'(w_eff));
   assign emit  = (SW'(r_ff) >= SW'({half, 1'b0})) && (SW'(c_ff) >= SW'({half, 1'b0}));
   assign in_border = (cr < bm) || (cr > hgt_s - bm) || (cc < bm) || (cc > wid_s - bm);

   // Column sum for the window column under the sum index, rows outside the kernel masked.
   logic [IDX_W-1:0] idx_ff;
   logic [SUM_W-1:0] col_sum;
   logic [SUM_W-1:0] acc_ff;

   always_comb begin
      col_sum = '0;
      for (int i = 0; i < WIN; i++) begin
         if (IDX_W'(i) >= lo) begin
            col_sum = col_sum + SUM_W'(win_ff[i][idx_ff]);
         end
      end
   end

   // The last column always lies inside the kernel, so the divider takes the
   // running sum together with that column's sum.
   logic             div_start;
   logic             div_done;
   logic [SUM_W-1:0] div_quot;
   logic [SUM_W-1:0] div_numer;

   assign div_numer = acc_ff + col_sum;

   bmf_divider #(
      .NUM_W (SUM_W),
      .DEN_W (DIVR_W)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (divisor),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Sequencer: one transaction at a time. The result register holds a finished result
   // while the output side stalls, and the sequencer waits in ST_OUT until it is free.
   logic [OUT_POS_W-1:0] orow_ff, ocol_ff;
   logic [PIX_W-1:0]     val_ff;
   logic                 rsp_valid_ff;
   logic [OUT_POS_W-1:0] rsp_row_ff, rsp_col_ff;
   logic [PIX_W-1:0]     rsp_luma_ff;
   logic                 rsp_load;

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_filtered_luma = rsp_luma_ff;
   assign div_start         = (state_ff == ST_SUM) && (idx_ff == IDX_W'(WIN - 1));
   assign rsp_load          = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         idx_ff       <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_SHIFT;
               end
            end
            ST_SHIFT: begin
               idx_ff <= '0;
               if (!emit) begin
                  state_ff <= ST_IDLE;
               end else if (in_border) begin
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               idx_ff <= idx_ff + IDX_W'(1);
               if (idx_ff == IDX_W'(WIN - 1)) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (rsp_load) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         c_ff    <= c_now;
         r_ff    <= r_now;
         luma_ff <= req_luma;
      end
      case (state_ff)
         ST_SHIFT: begin
            acc_ff  <= '0;
            orow_ff <= cr[OUT_POS_W-1:0];
            ocol_ff <= cc[OUT_POS_W-1:0];
            val_ff  <= BORDER_VALUE;
         end
         ST_SUM: begin
            if (idx_ff >= lo) begin
               acc_ff <= acc_ff + col_sum;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               val_ff <= div_quot[PIX_W-1:0];
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               rsp_row_ff  <= orow_ff;
               rsp_col_ff  <= ocol_ff;
               rsp_luma_ff <= val_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

FILE: hw/rtl/bmf_checker.sv
// Port-level checker for the box mean filter, bound to the top level.
module bmf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [bmf_pkg::OUT_POS_W-1:0] rsp_out_row,
   input logic [bmf_pkg::OUT_POS_W-1:0] rsp_out_col,
   input logic [bmf_pkg::PIX_W-1:0]     rsp_filtered_luma
);
   // A waiting result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_row) &&
      $stable(rsp_out_col) && $stable(rsp_filtered_luma))
      else $error("result changed while stalled");

   // After reset no result is shown.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Only one transaction is in work at a time.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after acceptance");

   // A new result appears only while the input side is busy.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared with no transaction in work");

endmodule

bind box_mean_filter_with_border bmf_checker u_bmf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_out_row       (rsp_out_row),
   .rsp_out_col       (rsp_out_col),
   .rsp_filtered_luma (rsp_filtered_luma)
);

FILE: dv/tb_top.sv
// Self-checking testbench for the box mean filter with border.
module tb_top;
   import bmf_pkg::*;

   localparam int LINE_MAX   = 1024;
   localparam int FRAME_MAX  = 1024;
   localparam int WIN_MAX    = 7;
   localparam int HOLD_OFF   = 40;
   localparam int CYCLE_CAP  = 3000000;
   localparam int BULK_ITEMS = 820;
   localparam int WIDE_CUT   = 20;

   typedef struct {
      logic [OUT_POS_W-1:0] row;
      logic [OUT_POS_W-1:0] col;
      logic [PIX_W-1:0]     luma;
   } mean_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [PIX_W-1:0] req_luma = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_POS_W-1:0] rsp_out_row;
   logic [OUT_POS_W-1:0] rsp_out_col;
   logic [PIX_W-1:0] rsp_filtered_luma;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [APB_ADDR_W-1:0] paddr = '0;
   logic [APB_DATA_W-1:0] pwdata = '0;
   logic [APB_DATA_W-1:0] prdata;
   logic pready;

   box_mean_filter_with_border dut (.*);

   always #2 clock = ~clock;

   // Pixels waiting to be sent, and filtered pixels predicted but not yet seen.
   logic [PIX_W-1:0] pixel_q[$];
   mean_result_t     mean_q[$];
   int               error_count = 0;
   int               cycle_count = 0;

   // Shadow of the configuration registers as the block holds them.
   logic [DIM_W-1:0] shadow_width  = RST_IMAGE_WIDTH;
   logic [DIM_W-1:0] shadow_height = RST_IMAGE_HEIGHT;
   logic [KER_W-1:0] shadow_kernel = RST_KERNEL_SIZE;
   logic [DIM_W-1:0] shadow_border = RST_BORDER_MARGIN;

   // Filter state: six line buffers, the 7x7 window and the raster position.
   logic [PIX_W-1:0] line_buf[WIN_MAX-1][LINE_MAX];
   logic [PIX_W-1:0] win_buf[WIN_MAX][WIN_MAX];
   int unsigned      pos_row = 0;
   int unsigned      pos_col = 0;

   initial begin
      foreach (line_buf[i, j]) line_buf[i][j] = '0;
      foreach (win_buf[i, j]) win_buf[i][j] = '0;
   end

   // Takes one luma byte through the filter and queues the output pixel it yields, if any.
   task automatic filter_pixel(input logic [PIX_W-1:0] luma);
      int unsigned w, hg, half, divisor, lo, sum, value;
      int cr, cc, bm;
      logic [PIX_W-1:0] column[WIN_MAX];
      mean_result_t res;
      w  = (shadow_width == 0) ? 1 : (shadow_width > LINE_MAX) ? LINE_MAX : shadow_width;
      hg = (shadow_height == 0) ? 1 : (shadow_height > FRAME_MAX) ? FRAME_MAX : shadow_height;
      half = (shadow_kernel >= 1) ? (shadow_kernel - 1) / 2 : 0;
      if (half > (WIN_MAX - 1) / 2) half = (WIN_MAX - 1) / 2;
      divisor = shadow_kernel * shadow_kernel;
      if (divisor == 0) divisor = 1;
      if (pos_col >= w) pos_col = 0;
      if (pos_row >= hg) pos_row = 0;
      // The new column: oldest row on top, the arriving pixel at the bottom.
      for (int i = 0; i < WIN_MAX - 1; i++) column[i] = line_buf[WIN_MAX - 2 - i][pos_col];
      column[WIN_MAX - 1] = luma;
      for (int j = WIN_MAX - 2; j >= 1; j--) line_buf[j][pos_col] = line_buf[j - 1][pos_col];
      line_buf[0][pos_col] = luma;
      for (int i = 0; i < WIN_MAX; i++) begin
         for (int j = 0; j < WIN_MAX - 1; j++) win_buf[i][j] = win_buf[i][j + 1];
         win_buf[i][WIN_MAX - 1] = column[i];
      end
      if (pos_row >= 2 * half && pos_col >= 2 * half) begin
         cr = pos_row - half;
         cc = pos_col - half;
         bm = shadow_border;
         if (cr < bm || cr > int'(hg) - bm || cc < bm || cc > int'(w) - bm) begin
            value = BORDER_VALUE;
         end else begin
            sum = 0;
            lo = WIN_MAX - 1 - 2 * half;
            for (int i = lo; i < WIN_MAX; i++)
               for (int j = lo; j < WIN_MAX; j++) sum += win_buf[i][j];
            value = sum / divisor;
         end
         res.row  = cr[OUT_POS_W-1:0];
         res.col  = cc[OUT_POS_W-1:0];
         res.luma = value[PIX_W-1:0];
         mean_q.push_back(res);
      end
      pos_col++;
      if (pos_col >= w) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= hg) pos_row = 0;
      end
   endtask

   // Sender: bursts of random length separated by random gaps; a gap of
   // zero gives long stretches with valid held high.
   int  burst_left = 8;
   int  gap_left = 0;
   logic req_fire = 1'b0;

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pixel_q.size() > 0) begin
            req_valid <= 1'b1;
            req_luma <= pixel_q.pop_front();
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 30);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: the chance of being ready is redrawn from four levels so that
   // both free-flowing and heavily stalled stretches occur.
   int ready_pct = 100;

   always @(negedge clock) begin
      if (cycle_count % 300 == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 70;
            2: ready_pct = 30;
            default: ready_pct = 10;
         endcase
      end
      rsp_ready <= ($urandom_range(0, 99) < ready_pct);
   end

   // Monitor: compares every result transaction with the oldest prediction
   // and feeds every accepted input transaction into the predictor.
   always @(posedge clock) begin
      mean_result_t want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("[box_mean_filter_with_border] ERROR");
         $finish;
      end
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (mean_q.size() == 0) begin
               $error("unexpected result row %0d col %0d luma %0d",
                      rsp_out_row, rsp_out_col, rsp_filtered_luma);
               error_count++;
            end else begin
               want = mean_q.pop_front();
               if (rsp_out_row !== want.row) begin
                  $error("out_row expected %0d actual %0d", want.row, rsp_out_row);
                  error_count++;
               end
               if (rsp_out_col !== want.col) begin
                  $error("out_col expected %0d actual %0d", want.col, rsp_out_col);
                  error_count++;
               end
               if (rsp_filtered_luma !== want.luma) begin
                  $error("filtered_luma expected %0d actual %0d", want.luma,
                         rsp_filtered_luma);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) filter_pixel(req_luma);
      end
   end

   // One register write: setup phase, then access phase.
   task automatic csr_write(input logic [1:0] index, input logic [APB_DATA_W-1:0] value);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= APB_ADDR_W'(4 * index);
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_IMAGE_WIDTH:   shadow_width  = value[DIM_W-1:0];
         REG_IMAGE_HEIGHT:  shadow_height = value[DIM_W-1:0];
         REG_KERNEL_SIZE:   shadow_kernel = value[KER_W-1:0];
         default:           shadow_border = value[DIM_W-1:0];
      endcase
   endtask

   // Waits until every pixel is accepted and every result has arrived, then
   // lets the block finish any pixel that produces no result.
   task automatic wait_drained();
      while (pixel_q.size() > 0 || req_valid || mean_q.size() > 0) @(posedge clock);
      repeat (HOLD_OFF) @(posedge clock);
   endtask

   // Writes all four registers and sends whole frames, so that every frame
   // starts at row 0, column 0 and every result uses only pixels of its own frame.
   task automatic run_frames(input int unsigned w, input int unsigned hg, input int unsigned k,
                             input int unsigned bm, input int frames, input bit extremes);
      int unsigned ew, eh;
      wait_drained();
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, hg);
      csr_write(REG_KERNEL_SIZE, k);
      csr_write(REG_BORDER_MARGIN, bm);
      ew = (w == 0) ? 1 : (w > LINE_MAX) ? LINE_MAX : w;
      eh = (hg == 0) ? 1 : (hg > FRAME_MAX) ? FRAME_MAX : hg;
      for (int n = 0; n < frames * ew * eh; n++)
         pixel_q.push_back(extremes ? ((n % 2) ? 8'hFF : 8'h00) : PIX_W'($urandom));
   endtask

   int sent;

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extreme pixel values, then the size clamps, even and zero
      // kernels, the largest kernel and border margins of every reach.
      run_frames(5, 5, 3, 0, 1, 1);
      run_frames(0, 0, 0, 0, 2, 0);
      run_frames(4, 4, 7, 0, 1, 1);
      run_frames(7, 7, 7, 0, 1, 0);
      run_frames(6, 5, 2, 1, 1, 0);
      run_frames(6, 6, 4, 1, 1, 0);
      run_frames(8, 7, 6, 0, 1, 0);
      run_frames(6, 6, 5, 2047, 1, 0);
      run_frames(5, 4, 1, 2, 1, 0);
      // An over-wide single-row frame, cut short after a few pixels. The
      // border test sees the clamped width. Every random frame that follows
      // is narrower than the cut, so its column restarts at zero.
      run_frames(2047, 1, 0, 1024, 0, 0);
      for (int n = 0; n < WIDE_CUT; n++) pixel_q.push_back(PIX_W'($urandom));

      // Random frames, mostly small, until enough pixels have gone out.
      sent = 0;
      while (sent < BULK_ITEMS) begin
         int unsigned w, hg, k, bm;
         w  = $urandom_range(1, 16);
         hg = $urandom_range(1, 10);
         k  = $urandom_range(0, 7);
         bm = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 3);
         run_frames(w, hg, k, bm, $urandom_range(1, 2), 0);
         sent += pixel_q.size();
      end

      wait_drained();
      if (error_count == 0) begin
         $display("[box_mean_filter_with_border] OK");
      end else begin
         $display("[box_mean_filter_with_border] ERROR");
      end
      $finish;
   end

endmodule
